// ===== sv/gclk_pkg.sv =====
// Package with shared types and constants of the GCLOCK replacement core.
`default_nettype none
package gclk_pkg;
  localparam int ENTRIES = 1024;
  localparam int IDX_W = 10;
  localparam int UTIL_W = 16;

  typedef enum logic [2:0] {
    CMD_WRITE = 3'd0, CMD_TOUCH = 3'd1, CMD_ADVANCE = 3'd2,
    CMD_EVICT = 3'd3, CMD_READ = 3'd4
  } cmd_t;

  localparam logic [2:0] CFG_ENTRIES = 3'd0;
  localparam logic [2:0] CFG_ADVANCE = 3'd1;
  localparam logic [2:0] CFG_DEC = 3'd2;
  localparam logic [2:0] CFG_INC = 3'd3;
  localparam logic [2:0] CFG_CEIL = 3'd4;
  localparam logic [2:0] CFG_LAPS = 3'd5;

  localparam logic [1:0] ST_FREE = 2'd0;
  localparam logic [1:0] ST_CACHED = 2'd1;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_RD, S_RDW, S_TOUCH, S_STEP, S_SRD, S_SRDW, S_SUPD, S_SUM,
    S_FIN, S_FRD, S_FRDW, S_DONE
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clear_step;
    logic load;
    logic rd_idx;
    logic rd_hand;
    logic touch_wr;
    logic step;
    logic upd;
    logic sum;
    logic emit;
  } ctl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clear_done;
    logic [2:0] cmd;
    logic idx_ok;
    logic adv_done;
    logic stop_laps;
    logic evict_target;
    logic util_zero;
    logic req_met;
  } sts_t;
endpackage
`default_nettype wire

// ===== sv/gclock_cache_replacement_core.sv =====
// Top level of the GCLOCK cache replacement core.
// After reset the core clears its 1024-entry table, one entry per cycle, with busy high.
// Advance and evict step the hand entry by entry; each step reads the entry under the
// hand from the table memory and, where it updates it, writes it back.
// Each result appears for one cycle with out_valid; the receiver cannot stall it.
`default_nettype none
module gclock_cache_replacement_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [2:0]  in_cmd,
  input  wire logic [9:0]  in_entry_index,
  input  wire logic [1:0]  in_new_state,
  input  wire logic [15:0] in_new_pins,
  input  wire logic [31:0] in_new_size,
  input  wire logic [15:0] in_new_utility,
  input  wire logic [43:0] in_request_size,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_data,
  output logic             out_valid,
  output logic [41:0]      out_freed_size,
  output logic [10:0]      out_victim_count,
  output logic             out_gave_up,
  output logic [1:0]       out_read_state,
  output logic [15:0]      out_read_pins,
  output logic [31:0]      out_read_size,
  output logic [15:0]      out_read_utility,
  output logic [9:0]       out_hand_position
);
  import gclk_pkg::*;
  ctl_t ctl;
  sts_t sts;

  assign cfg_ready = 1'b1;

  gclk_ctrl u_ctrl (.clk, .rst_n, .start, .busy, .sts, .ctl);

  gclk_dp u_dp (
    .clk, .rst_n, .ctl, .sts, .in_cmd, .in_entry_index, .in_new_state, .in_new_pins,
    .in_new_size, .in_new_utility, .in_request_size,
    .cfg_we(cfg_valid), .cfg_idx(cfg_index), .cfg_data,
    .out_valid, .out_freed_size, .out_victim_count, .out_gave_up, .out_read_state,
    .out_read_pins, .out_read_size, .out_read_utility, .out_hand_position
  );
endmodule
`default_nettype wire

// ===== sv/gclk_ctrl.sv =====
// Controller state machine sequencing commands over the entry table.
`default_nettype none
module gclk_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  output logic               busy,
  input  gclk_pkg::sts_t     sts,
  output gclk_pkg::ctl_t     ctl
);
  import gclk_pkg::*;
  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_CLEAR;
    else state_r <= state_nxt;
  end

  // Next state and command decode.
  always_comb begin
    state_nxt = state_r;
    ctl = '0;
    busy = (state_r != S_IDLE);
    case (state_r)
      S_CLEAR: begin
        ctl.clear_step = 1'b1;
        if (sts.clear_done) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          ctl.load = 1'b1;
          state_nxt = S_RD;
        end
      end
      S_RD: begin
        case (sts.cmd)
          CMD_ADVANCE: state_nxt = S_STEP;
          CMD_EVICT: state_nxt = S_STEP;
          CMD_TOUCH: begin
            ctl.rd_idx = 1'b1;
            state_nxt = sts.idx_ok ? S_RDW : S_FIN;
          end
          default: state_nxt = S_FIN;
        endcase
      end
      // Keep the addressed entry on the read port while its data settles.
      S_RDW: begin
        ctl.rd_idx = 1'b1;
        state_nxt = S_TOUCH;
      end
      S_TOUCH: begin
        ctl.touch_wr = 1'b1;
        state_nxt = S_FIN;
      end
      S_STEP: begin
        if (sts.cmd == CMD_ADVANCE && sts.adv_done) state_nxt = S_FIN;
        else begin
          ctl.step = 1'b1;
          state_nxt = S_SRD;
        end
      end
      S_SRD: begin
        if (sts.cmd == CMD_EVICT && sts.stop_laps) state_nxt = S_FIN;
        else begin
          ctl.rd_hand = 1'b1;
          state_nxt = S_SRDW;
        end
      end
      S_SRDW: state_nxt = S_SUPD;
      S_SUPD: begin
        if (sts.cmd == CMD_EVICT && !sts.evict_target) state_nxt = S_STEP;
        else begin
          ctl.upd = 1'b1;
          state_nxt = (sts.cmd == CMD_EVICT) ? S_SUM : S_STEP;
        end
      end
      S_SUM: begin
        if (sts.util_zero) begin
          ctl.sum = 1'b1;
          state_nxt = S_DONE;
        end else state_nxt = S_STEP;
      end
      S_DONE: state_nxt = sts.req_met ? S_FIN : S_STEP;
      S_FIN: begin
        ctl.rd_idx = 1'b1;
        state_nxt = S_FRD;
      end
      S_FRD: begin
        ctl.rd_idx = 1'b1;
        state_nxt = S_FRDW;
      end
      S_FRDW: begin
        ctl.emit = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end
endmodule
`default_nettype wire

// ===== sv/gclk_dp.sv =====
// Datapath: entry table memory, clock hand, lap counting and result registers.
`default_nettype none
module gclk_dp (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  gclk_pkg::ctl_t     ctl,
  output gclk_pkg::sts_t     sts,
  input  wire logic [2:0]    in_cmd,
  input  wire logic [9:0]    in_entry_index,
  input  wire logic [1:0]    in_new_state,
  input  wire logic [15:0]   in_new_pins,
  input  wire logic [31:0]   in_new_size,
  input  wire logic [15:0]   in_new_utility,
  input  wire logic [43:0]   in_request_size,
  input  wire logic          cfg_we,
  input  wire logic [2:0]    cfg_idx,
  input  wire logic [15:0]   cfg_data,
  output logic               out_valid,
  output logic [41:0]        out_freed_size,
  output logic [10:0]        out_victim_count,
  output logic               out_gave_up,
  output logic [1:0]         out_read_state,
  output logic [15:0]        out_read_pins,
  output logic [31:0]        out_read_size,
  output logic [15:0]        out_read_utility,
  output logic [9:0]         out_hand_position
);
  import gclk_pkg::*;
  localparam int WORD_W = 2 + 16 + 32 + UTIL_W;

  // Configuration registers.
  logic [10:0] ent_r, adv_r;
  logic [15:0] dec_cfg_r, inc_r, ceil_r;
  logic [9:0] laps_cfg_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_r <= 11'd1024; adv_r <= 11'd50; dec_cfg_r <= 16'd7;
      inc_r <= 16'd500; ceil_r <= 16'hFFFF; laps_cfg_r <= 10'd100;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_ENTRIES: ent_r <= cfg_data[10:0];
        CFG_ADVANCE: adv_r <= cfg_data[10:0];
        CFG_DEC: dec_cfg_r <= cfg_data;
        CFG_INC: inc_r <= cfg_data;
        CFG_CEIL: ceil_r <= cfg_data;
        CFG_LAPS: laps_cfg_r <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

  // Entry table memory: {state, pins, size, utility}.
  logic [WORD_W-1:0] mem [ENTRIES];
  logic [WORD_W-1:0] rdata_r;
  logic [IDX_W-1:0] waddr, raddr;
  logic [WORD_W-1:0] wdata;
  logic we;

  logic [2:0] cmd_r;
  logic [IDX_W-1:0] idx_r, hand_r, clr_r;
  logic [1:0] nst_r;
  logic [15:0] npin_r, nutil_r;
  logic [31:0] nsize_r;
  logic [43:0] req_r;
  logic [10:0] cnt_r, vict_r;
  logic [10:0] laps_r;
  logic found_r, gave_r, clr_done_r;
  logic [UTIL_W-1:0] dec_r;
  logic [43:0] freed_r;

  wire [1:0] r_st = rdata_r[WORD_W-1 -: 2];
  wire [15:0] r_pin = rdata_r[WORD_W-3 -: 16];
  wire [31:0] r_size = rdata_r[UTIL_W +: 32];
  wire [UTIL_W-1:0] r_util = rdata_r[UTIL_W-1:0];
  wire [UTIL_W-1:0] cur_dec = (cmd_r == CMD_EVICT) ? dec_r : dec_cfg_r;
  wire [UTIL_W-1:0] sub_util = (r_util > cur_dec) ? r_util - cur_dec : '0;
  wire [16:0] tsum = {1'b0, r_util} + {1'b0, inc_r};
  wire [UTIL_W-1:0] tval = (tsum > {1'b0, ceil_r}) ? ceil_r : tsum[15:0];
  wire [10:0] sweep = (ent_r == 11'd0) ? 11'd1 : (ent_r > 11'd1024 ? 11'd1024 : ent_r);
  wire [10:0] hnext = {1'b0, hand_r} + 11'd1;
  wire wrap = hnext >= sweep;
  wire [UTIL_W-1:0] dbl = (dec_r <= (ceil_r >> 1)) ? {dec_r[UTIL_W-2:0], 1'b0} : ceil_r;

  // Memory write and read port selection.
  always_comb begin
    we = 1'b0; waddr = hand_r; wdata = rdata_r; raddr = hand_r;
    if (ctl.clear_step) begin
      we = 1'b1; waddr = clr_r; wdata = '0;
    end else if (ctl.load && in_cmd == CMD_WRITE) begin
      we = 1'b1; waddr = in_entry_index;
      wdata = {in_new_state, in_new_pins, in_new_size, in_new_utility};
    end else if (ctl.touch_wr) begin
      we = 1'b1; waddr = idx_r; wdata = {r_st, r_pin, r_size, tval};
    end else if (ctl.upd) begin
      we = 1'b1; wdata = {r_st, r_pin, r_size, sub_util};
    end else if (ctl.sum) begin
      // The read data still holds the utility from before the update, which is now zero.
      we = 1'b1; wdata = {ST_FREE, r_pin, r_size, {UTIL_W{1'b0}}};
    end
    if (ctl.rd_idx) raddr = idx_r;
    else if (ctl.rd_hand) raddr = hand_r;
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata_r <= mem[raddr];
  end

  // Clear sweep, hand, counters and eviction bookkeeping.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r <= '0; clr_done_r <= 1'b0; hand_r <= '0; out_valid <= 1'b0;
    end else begin
      out_valid <= ctl.emit;
      if (ctl.clear_step) begin
        clr_r <= clr_r + 1'b1;
        if (clr_r == IDX_W'(ENTRIES - 1)) clr_done_r <= 1'b1;
      end
      if (ctl.load) begin
        cmd_r <= in_cmd; idx_r <= in_entry_index; req_r <= in_request_size;
        cnt_r <= '0; vict_r <= '0; laps_r <= '0; found_r <= 1'b0;
        gave_r <= 1'b0; dec_r <= dec_cfg_r; freed_r <= '0;
      end
      if (ctl.step) begin
        hand_r <= wrap ? '0 : hnext[IDX_W-1:0];
        cnt_r <= cnt_r + 11'd1;
        if (wrap) begin
          laps_r <= laps_r + 11'd1;
          if (!found_r) dec_r <= dbl;
          found_r <= 1'b0;
          if (cmd_r == CMD_EVICT && laps_r + 11'd1 > {1'b0, laps_cfg_r}) gave_r <= 1'b1;
        end
      end
      if (ctl.upd && cmd_r == CMD_EVICT && dec_r != '0) laps_r <= '0;
      if (ctl.sum) begin
        found_r <= 1'b1;
        freed_r <= freed_r + {12'd0, r_size};
        vict_r <= vict_r + 11'd1;
      end
      if (ctl.emit) begin
        out_freed_size <= freed_r[41:0];
        out_victim_count <= vict_r;
        out_gave_up <= gave_r;
        out_hand_position <= hand_r;
        out_read_state <= r_st; out_read_pins <= r_pin;
        out_read_size <= r_size; out_read_utility <= r_util;
      end
    end
  end

  // Whether the utility of the entry just updated is zero, seen in the cycle after.
  logic uz_r;
  always_ff @(posedge clk) uz_r <= (sub_util == '0);

  always_comb begin
    sts.clear_done = clr_done_r;
    sts.cmd = cmd_r;
    sts.idx_ok = 1'b1;
    sts.adv_done = (cnt_r >= adv_r);
    sts.stop_laps = gave_r;
    sts.evict_target = (r_st == ST_CACHED) && (r_pin == 16'd0);
    sts.util_zero = uz_r;
    sts.req_met = (freed_r >= req_r);
  end

  // The hand stays within the 1024-entry table; each emit is followed by a result strobe.
  always_ff @(posedge clk) begin
    if (rst_n && clr_done_r) begin
      assert ({1'b0, hand_r} < 11'd1024) else $error("hand out of range");
    end
  end
  assert property (@(posedge clk) disable iff (!rst_n) ctl.emit |=> out_valid)
    else $error("result strobe missing");
  assert property (@(posedge clk) disable iff (!rst_n) ctl.sum |-> uz_r)
    else $error("evicted entry with nonzero utility");
  assert property (@(posedge clk) disable iff (!rst_n) ctl.step |-> !ctl.upd)
    else $error("step and update overlap");
endmodule
`default_nettype wire
